// File: rtl/vwap_window_order_gate_macros.svh
// Assertion helper macros for the rolling-window VWAP gate.
`ifndef VWAP_WINDOW_ORDER_GATE_MACROS_SVH
`define VWAP_WINDOW_ORDER_GATE_MACROS_SVH

// Implication checked every clock edge outside reset.
`define VWG_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vwg check failed");

// Next-cycle implication.
`define VWG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vwg sequence check failed");

`endif

// File: rtl/vwg_pkg.sv
//------------------------------------------------------------------------------
// vwg_pkg
// Shared constants, codes and types of the rolling-window VWAP gate.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package vwg_pkg;

   localparam int DEF_RING_DEPTH   = 1024;
   localparam int DEF_WARMUP_COUNT = 10;

   localparam logic [23:0] BAND_DEN = 24'd10000000;
   localparam logic [16:0] CAP_ONE  = 17'd65536;

   localparam logic [1:0] CSR_WINDOW = 2'd0;
   localparam logic [1:0] CSR_MAXQTY = 2'd1;
   localparam logic [1:0] CSR_BAND   = 2'd2;
   localparam logic [1:0] CSR_CAP    = 2'd3;

   localparam logic [1:0] SIDE_UNKNOWN = 2'd0;
   localparam logic [1:0] SIDE_BUY     = 2'd1;
   localparam logic [1:0] SIDE_SELL    = 2'd2;

   typedef enum logic [2:0] {
      VERDICT_NO_ORDER    = 3'd0,
      VERDICT_MARKET      = 3'd1,
      VERDICT_ACCEPTED    = 3'd2,
      VERDICT_PARTIAL_MAX = 3'd3,
      VERDICT_PARTIAL_CAP = 3'd4,
      VERDICT_REJECT_BAND = 3'd5,
      VERDICT_REJECT_CAP  = 3'd6
   } verdict_type;

   // Ring entry as stored in the memory.
   typedef struct packed {
      logic [63:0] time_ns;
      logic [19:0] qty;
      logic [51:0] notional;
      logic        user;
   } entry_type;

   // Divider request / status between the sequencer and the divider.
   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [63:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quotient;
   } div_rsp_type;

endpackage

// File: rtl/vwg_divider.sv
//------------------------------------------------------------------------------
// vwg_divider
// Radix-2 restoring divider, one quotient bit per cycle.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module vwg_divider
   import vwg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [63:0] quo_ff, quo_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] dvs_ff, dvs_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] shifted;
   logic [64:0] diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[63]};
      diff    = shifted - {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         cnt_in  = 7'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so bit 64 is never needed
         if (!diff[64]) begin
            rem_in = diff[63:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = shifted[63:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// File: rtl/vwg_ring.sv
//------------------------------------------------------------------------------
// vwg_ring
// Ring memory of trade entries with one write port and one read port, registered read.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module vwg_ring
   import vwg_pkg::*;
#(
   parameter int RING_DEPTH = DEF_RING_DEPTH,
   localparam int AW = $clog2(RING_DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  entry_type     wr_data,
   input  logic [AW-1:0] rd_addr,
   output entry_type     rd_data
);

   entry_type mem [RING_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: rtl/vwap_window_order_gate.sv
//------------------------------------------------------------------------------
// vwap_window_order_gate
// Rolling time-window VWAP with a user order gate.
//------------------------------------------------------------------------------
// Usage:
//  - A print is a transaction on the req_ ports: it is taken when start is
//    high and busy is low. busy drops in the cycle the result is strobed.
//  - Each print yields one result on the rsp_ ports for one cycle, marked by
//    rsp_valid. The receiver cannot stall; nothing holds results back.
//  - Per print the block steps through a read of the oldest entry, repeated
//    for each evicted entry, a VWAP division when market quantity is held,
//    band and cap math for user prints past the gate, a cap division for
//    those that hit the cap, and after an insert a VWAP division when market
//    quantity is held. All divisions share the one bit-serial divider. One
//    print is in flight at a time.
//  - csr_ writes (index 0..3) are taken at any time with csr_ready high;
//    they must only be issued while the block is idle.
//  - Reset (synchronous, active high) clears pointers, sums, warm-up state
//    and registers to defaults. The ring memory is not cleared: the fill
//    count marks which entries are valid.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module vwap_window_order_gate
   import vwg_pkg::*;
#(
   parameter int RING_DEPTH   = DEF_RING_DEPTH,
   parameter int WARMUP_COUNT = DEF_WARMUP_COUNT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_timestamp_ns,
   input  logic [31:0] req_price,
   input  logic [19:0] req_quantity,
   input  logic [51:0] req_notional,
   input  logic        req_is_user,
   input  logic [1:0]  req_side_in,
   output logic        rsp_valid,
   output logic [2:0]  rsp_verdict,
   output logic [1:0]  rsp_side_out,
   output logic [19:0] rsp_submitted_qty,
   output logic [19:0] rsp_granted_qty,
   output logic [31:0] rsp_window_vwap,
   output logic        rsp_overflow,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);
`include "vwap_window_order_gate_macros.svh"

   localparam int AW = $clog2(RING_DEPTH);
   localparam int CW = AW + 1;
   localparam logic [CW-1:0] DEPTH_C  = CW'(RING_DEPTH);
   localparam logic [CW-1:0] WARM_C   = CW'(WARMUP_COUNT);
   localparam logic [7:0]    WARM8_C  = 8'(WARMUP_COUNT);
   localparam logic [AW-1:0] LAST_PTR = AW'(RING_DEPTH - 1);

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b00000000001,
      ST_READ  = 11'b00000000010,
      ST_WAIT  = 11'b00000000100,
      ST_CHECK = 11'b00000001000,
      ST_DIV1  = 11'b00000010000,
      ST_DEC   = 11'b00000100000,
      ST_MUL   = 11'b00001000000,
      ST_CAP   = 11'b00010000000,
      ST_DIV2  = 11'b00100000000,
      ST_INS   = 11'b01000000000,
      ST_DIV3  = 11'b10000000000
   } state_type;

   state_type   state_ff, state_in;

   // configuration registers
   logic [63:0] window_ff;
   logic [19:0] maxq_ff;
   logic [23:0] band_ff;
   logic [16:0] lim_ff;

   // architectural state
   logic [AW-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [61:0]   mnot_ff, mnot_in;
   logic [29:0]   mqty_ff, mqty_in;
   logic [29:0]   uqty_ff, uqty_in;
   logic [31:0]   vwap_ff, vwap_in;
   logic          warm_ff, warm_in;
   logic [63:0]   first_ff, first_in;
   logic [7:0]    seen_ff, seen_in;

   // captured transaction
   logic [63:0] ts_ff, ts_in;
   logic [31:0] price_ff, price_in;
   logic [19:0] qty_ff, qty_in;
   logic [51:0] not_ff, not_in;
   logic        user_ff, user_in;
   logic [1:0]  side_ff, side_in_w;
   logic [63:0] cutoff_ff, cutoff_in;

   // working result
   verdict_type verd_ff, verd_in;
   logic [19:0] sub_ff, sub_in;
   logic [19:0] gq_ff, gq_in;
   logic        ins_ff, ins_in;
   logic        ovf_ff, ovf_in;
   logic [57:0] lhs_ff, lhs_in;
   logic [57:0] rhs_ff, rhs_in;
   logic [47:0] ut_ff, ut_in;
   logic [47:0] lt_ff, lt_in;

   logic        rv_ff, rv_in;

   entry_type   rd_data, wr_data;
   logic        wr_en;
   div_req_type div_req;
   div_rsp_type div_rsp;

   vwg_ring #(.RING_DEPTH(RING_DEPTH)) u_ring (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wptr_ff),
      .wr_data(wr_data),
      .rd_addr(rptr_ff),
      .rd_data(rd_data)
   );

   vwg_divider u_div (
      .clock  (clock),
      .reset  (reset),
      .div_req(div_req),
      .div_rsp(div_rsp)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // band and cap arithmetic helpers
   logic [23:0] band_c;
   logic [19:0] q_clamp;
   logic [29:0] u_sum;
   logic [30:0] t_sum;
   logic [29:0] allowed;
   logic [63:0] maxu;
   logic [31:0] vwap_sat;

   always_comb begin
      band_c   = (band_ff > BAND_DEN) ? BAND_DEN : band_ff;
      q_clamp  = (qty_ff > maxq_ff) ? maxq_ff : qty_ff;
      u_sum    = uqty_ff + 30'(q_clamp);
      t_sum    = 31'(mqty_ff) + 31'(u_sum);
      maxu     = div_rsp.quotient;
      allowed  = (maxu > 64'(uqty_ff)) ? 30'(maxu - 64'(uqty_ff)) : 30'd0;
      vwap_sat = (div_rsp.quotient[63:32] != 32'd0) ? 32'hFFFFFFFF
                                                     : div_rsp.quotient[31:0];
   end

   always_comb begin
      state_in  = state_ff;
      wptr_in   = wptr_ff;
      rptr_in   = rptr_ff;
      fill_in   = fill_ff;
      mnot_in   = mnot_ff;
      mqty_in   = mqty_ff;
      uqty_in   = uqty_ff;
      vwap_in   = vwap_ff;
      warm_in   = warm_ff;
      first_in  = first_ff;
      seen_in   = seen_ff;
      ts_in     = ts_ff;
      price_in  = price_ff;
      qty_in    = qty_ff;
      not_in    = not_ff;
      user_in   = user_ff;
      side_in_w = side_ff;
      cutoff_in = cutoff_ff;
      verd_in   = verd_ff;
      sub_in    = sub_ff;
      gq_in     = gq_ff;
      ins_in    = ins_ff;
      ovf_in    = ovf_ff;
      lhs_in    = lhs_ff;
      rhs_in    = rhs_ff;
      ut_in     = ut_ff;
      lt_in     = lt_ff;
      rv_in     = 1'b0;
      wr_en     = 1'b0;
      wr_data   = '{time_ns: ts_ff, qty: gq_ff, notional: not_ff, user: user_ff};
      div_req   = '{start: 1'b0, dividend: 64'(mnot_ff), divisor: 64'(mqty_ff)};

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ts_in     = req_timestamp_ns;
               price_in  = req_price;
               qty_in    = req_quantity;
               not_in    = req_notional;
               user_in   = req_is_user;
               side_in_w = (req_side_in == 2'd3) ? SIDE_UNKNOWN : req_side_in;
               cutoff_in = (req_timestamp_ns >= window_ff)
                           ? req_timestamp_ns - window_ff : 64'd0;
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            // rptr_ff is presented to the memory this cycle
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (fill_ff != '0 && rd_data.time_ns < cutoff_ff) begin
               if (rd_data.user) begin
                  uqty_in = uqty_ff - 30'(rd_data.qty);
               end else begin
                  mnot_in = mnot_ff - 62'(rd_data.notional);
                  mqty_in = mqty_ff - 30'(rd_data.qty);
               end
               rptr_in  = (rptr_ff == LAST_PTR) ? '0 : rptr_ff + AW'(1);
               fill_in  = fill_ff - CW'(1);
               state_in = ST_READ;
            end else begin
               div_req.start = (mqty_ff != '0);
               if (mqty_ff == '0) begin
                  vwap_in  = '0;
                  state_in = ST_DEC;
               end else begin
                  state_in = ST_DIV1;
               end
            end
         end
         ST_DIV1: begin
            if (div_rsp.done) begin
               vwap_in  = vwap_sat;
               state_in = ST_DEC;
            end
         end
         ST_DEC: begin
            sub_in = '0;
            gq_in  = '0;
            ovf_in = 1'b0;
            ins_in = 1'b1;
            if (!user_ff) begin
               if (!warm_ff) begin
                  if (seen_ff == '0) begin
                     first_in = ts_ff;
                  end
                  if (seen_ff != 8'd255) begin
                     seen_in = seen_ff + 8'd1;
                  end
                  if (ts_ff >= (seen_ff == '0 ? ts_ff : first_ff) &&
                      ts_ff - (seen_ff == '0 ? ts_ff : first_ff) >= window_ff &&
                      (seen_ff == 8'd255 ? 8'd255 : seen_ff + 8'd1) >= WARM8_C) begin
                     warm_in = 1'b1;
                  end
               end
               verd_in  = VERDICT_MARKET;
               gq_in    = qty_ff;
               state_in = ST_INS;
            end else if (!warm_ff || fill_ff < WARM_C) begin
               verd_in  = VERDICT_NO_ORDER;
               ins_in   = 1'b0;
               state_in = ST_INS;
            end else begin
               if (side_ff == SIDE_UNKNOWN) begin
                  side_in_w = (price_ff <= vwap_ff) ? SIDE_BUY : SIDE_SELL;
               end
               sub_in   = qty_ff;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // band products for the two sides of the compare, and the cap products
            lhs_in = 58'(price_ff) * 58'(BAND_DEN);
            rhs_in = (side_ff == SIDE_BUY)
                     ? 58'(vwap_ff) * 58'(BAND_DEN - band_c)
                     : 58'(vwap_ff) * 58'(25'(BAND_DEN) + 25'(band_c));
            ut_in  = 48'(u_sum) * 48'(CAP_ONE);
            lt_in  = 48'(lim_ff) * 48'(t_sum);
            state_in = ST_CAP;
         end
         ST_CAP: begin
            gq_in = q_clamp;
            if ((side_ff == SIDE_BUY) ? (lhs_ff > rhs_ff) : (lhs_ff < rhs_ff)) begin
               verd_in  = VERDICT_REJECT_BAND;
               gq_in    = '0;
               ins_in   = 1'b0;
               state_in = ST_INS;
            end else begin
               verd_in = (qty_ff > maxq_ff) ? VERDICT_PARTIAL_MAX : VERDICT_ACCEPTED;
               if ((t_sum == '0) ? (lim_ff < CAP_ONE) : (ut_ff > lt_ff)) begin
                  if (lim_ff < CAP_ONE) begin
                     div_req.start    = 1'b1;
                     div_req.dividend = 64'(47'(lim_ff) * 47'(mqty_ff));
                     div_req.divisor  = 64'(CAP_ONE - lim_ff);
                     state_in = ST_DIV2;
                  end else begin
                     verd_in  = VERDICT_REJECT_CAP;
                     gq_in    = '0;
                     ins_in   = 1'b0;
                     state_in = ST_INS;
                  end
               end else begin
                  state_in = ST_INS;
               end
            end
         end
         ST_DIV2: begin
            if (div_rsp.done) begin
               if (allowed == '0) begin
                  verd_in = VERDICT_REJECT_CAP;
                  gq_in   = '0;
                  ins_in  = 1'b0;
               end else begin
                  verd_in = VERDICT_PARTIAL_CAP;
                  if (30'(gq_ff) > allowed) begin
                     gq_in = allowed[19:0];
                  end
               end
               state_in = ST_INS;
            end
         end
         ST_INS: begin
            if (ins_ff && fill_ff >= DEPTH_C) begin
               ovf_in   = 1'b1;
               rv_in    = 1'b1;
               state_in = ST_IDLE;
            end else if (ins_ff) begin
               wr_en   = 1'b1;
               wptr_in = (wptr_ff == LAST_PTR) ? '0 : wptr_ff + AW'(1);
               fill_in = fill_ff + CW'(1);
               if (user_ff) begin
                  uqty_in = uqty_ff + 30'(gq_ff);
               end else begin
                  mnot_in = mnot_ff + 62'(not_ff);
                  mqty_in = mqty_ff + 30'(gq_ff);
               end
               state_in = ST_DIV3;
            end else begin
               rv_in    = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_DIV3: begin
            // first cycle here launches the division on updated sums when market quantity is held
            if (mqty_ff == '0) begin
               vwap_in  = '0;
               rv_in    = 1'b1;
               state_in = ST_IDLE;
            end else if (ins_ff) begin
               div_req.start = 1'b1;
               ins_in        = 1'b0;
            end else if (div_rsp.done) begin
               vwap_in  = vwap_sat;
               rv_in    = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      ts_ff     <= ts_in;
      price_ff  <= price_in;
      qty_ff    <= qty_in;
      not_ff    <= not_in;
      user_ff   <= user_in;
      side_ff   <= side_in_w;
      cutoff_ff <= cutoff_in;
      sub_ff    <= sub_in;
      gq_ff     <= gq_in;
      ins_ff    <= ins_in;
      lhs_ff    <= lhs_in;
      rhs_ff    <= rhs_in;
      ut_ff     <= ut_in;
      lt_ff     <= lt_in;
      verd_ff   <= verd_in;
      ovf_ff    <= ovf_in;
      if (reset) begin
         state_ff  <= ST_IDLE;
         wptr_ff   <= '0;
         rptr_ff   <= '0;
         fill_ff   <= '0;
         mnot_ff   <= '0;
         mqty_ff   <= '0;
         uqty_ff   <= '0;
         vwap_ff   <= '0;
         warm_ff   <= 1'b0;
         first_ff  <= '0;
         seen_ff   <= '0;
         rv_ff     <= 1'b0;
         window_ff <= 64'd1000000000;
         maxq_ff   <= 20'hFFFFF;
         band_ff   <= '0;
         lim_ff    <= CAP_ONE;
      end else begin
         state_ff <= state_in;
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         fill_ff  <= fill_in;
         mnot_ff  <= mnot_in;
         mqty_ff  <= mqty_in;
         uqty_ff  <= uqty_in;
         vwap_ff  <= vwap_in;
         warm_ff  <= warm_in;
         first_ff <= first_in;
         seen_ff  <= seen_in;
         rv_ff    <= rv_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_WINDOW: window_ff <= csr_wdata;
               CSR_MAXQTY: maxq_ff   <= csr_wdata[19:0];
               CSR_BAND:   band_ff   <= csr_wdata[23:0];
               CSR_CAP:    lim_ff    <= csr_wdata[16:0];
               default:    window_ff <= window_ff;
            endcase
         end
      end
   end

   // result ports: registered, one-cycle strobe
   assign rsp_valid         = rv_ff;
   assign rsp_verdict       = verd_ff;
   assign rsp_side_out      = side_ff;
   assign rsp_submitted_qty = sub_ff;
   assign rsp_granted_qty   = user_ff ? gq_ff : 20'd0;
   assign rsp_window_vwap   = vwap_ff;
   assign rsp_overflow      = ovf_ff;

   `VWG_ASSERT_IMP(a_fill_bound, clock, reset, 1'b1, fill_ff <= DEPTH_C)
   `VWG_ASSERT_NEXT(a_rsp_idle, clock, reset, rv_in, state_ff == ST_IDLE)
   `VWG_ASSERT_IMP(a_no_write_full, clock, reset, wr_en, fill_ff < DEPTH_C)
   `VWG_ASSERT_NEXT(a_busy_on_start, clock, reset, start && !busy, busy)

endmodule

// File: tb/vwap_window_order_gate_tb.sv
//------------------------------------------------------------------------------
// vwap_window_order_gate_tb
// Self-checking bench for the rolling-window VWAP order gate. A scoreboard
// class holds its own copy of the ring, the sums and the warm-up gate and
// predicts one result per accepted print. Each rsp_ strobe is compared
// against the oldest prediction. Directed prints come first, then random
// phases that cover the window, clamp, band and cap settings.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module vwap_window_order_gate_tb;
   import vwg_pkg::*;

   localparam int          DEPTH   = DEF_RING_DEPTH;
   localparam int          WARMUP  = DEF_WARMUP_COUNT;
   localparam logic [63:0] BAND_ONE = 64'd10000000;
   localparam logic [63:0] CAP_FULL = 64'd65536;

   typedef struct {
      logic [63:0] ts;
      logic [31:0] price;
      logic [19:0] qty;
      logic [51:0] notional;
      logic        is_user;
      logic [1:0]  side;
   } print_type;

   typedef struct {
      logic [2:0]  verdict;
      logic [1:0]  side;
      logic [19:0] submitted;
      logic [19:0] granted;
      logic [31:0] vwap;
      logic        overflow;
   } gate_result_type;

   //---------------------------------------------------------------------------
   // Scoreboard: rolling-window predictor plus queue of expected results.
   //---------------------------------------------------------------------------
   class vwap_gate_scoreboard;
      bit [63:0] window_ns;
      bit [19:0] max_qty;
      bit [23:0] band;
      bit [16:0] cap;
      bit [63:0] ring_time[DEPTH];
      bit [19:0] ring_qty[DEPTH];
      bit [51:0] ring_notional[DEPTH];
      bit        ring_user[DEPTH];
      int unsigned wr_slot, rd_slot, held;
      bit [61:0] mkt_notional;
      bit [29:0] mkt_qty;
      bit [29:0] usr_qty;
      bit [31:0] vwap;
      bit        warm;
      bit [63:0] first_ts;
      int unsigned seen;
      gate_result_type expected_q[$];
      int errors;
      int results;
      int verdict_count[8];
      int overflow_count;

      function new();
         window_ns = 64'd1000000000;
         max_qty   = 20'hFFFFF;
         band      = '0;
         cap       = 17'd65536;
         wr_slot = 0; rd_slot = 0; held = 0;
         mkt_notional = '0; mkt_qty = '0; usr_qty = '0; vwap = '0;
         warm = 0; first_ts = '0; seen = 0;
         errors = 0; results = 0; overflow_count = 0;
         foreach (verdict_count[i]) verdict_count[i] = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [63:0] data);
         case (idx)
            CSR_WINDOW: window_ns = data;
            CSR_MAXQTY: max_qty   = data[19:0];
            CSR_BAND:   band      = data[23:0];
            CSR_CAP:    cap       = data[16:0];
            default: ;
         endcase
      endfunction

      function void recompute_vwap();
         bit [63:0] q;
         if (mkt_qty == 0) begin
            vwap = '0;
         end else begin
            q = 64'(mkt_notional) / 64'(mkt_qty);
            vwap = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Predict the result of one accepted print and queue it.
      function void note_print(print_type p);
         gate_result_type r;
         bit [63:0] cutoff, bnd, scaled, q, m, s, u, t, lim, maxu, allowed;
         bit [1:0]  side;
         bit        insert, crossed, exceed;
         side   = (p.side == 2'd3) ? SIDE_UNKNOWN : p.side;
         insert = 1;
         r.submitted = '0;
         r.granted   = '0;
         r.overflow  = 0;
         // expire entries that fell out of the window
         cutoff = (p.ts >= window_ns) ? p.ts - window_ns : 64'd0;
         while (held > 0 && ring_time[rd_slot] < cutoff) begin
            if (ring_user[rd_slot]) begin
               usr_qty = usr_qty - 30'(ring_qty[rd_slot]);
            end else begin
               mkt_notional = mkt_notional - 62'(ring_notional[rd_slot]);
               mkt_qty      = mkt_qty - 30'(ring_qty[rd_slot]);
            end
            rd_slot = (rd_slot + 1 >= DEPTH) ? 0 : rd_slot + 1;
            held--;
         end
         recompute_vwap();
         if (!p.is_user) begin
            if (!warm) begin
               if (seen == 0) first_ts = p.ts;
               if (seen < 255) seen++;
               if (p.ts >= first_ts && p.ts - first_ts >= window_ns && seen >= WARMUP)
                  warm = 1;
            end
            r.verdict = VERDICT_MARKET;
            r.granted = p.qty;
         end else if (!warm || held < WARMUP) begin
            r.verdict = VERDICT_NO_ORDER;
            insert = 0;
         end else begin
            bnd    = (64'(band) > BAND_ONE) ? BAND_ONE : 64'(band);
            scaled = 64'(p.price) * BAND_ONE;
            if (side == SIDE_UNKNOWN) side = (p.price <= vwap) ? SIDE_BUY : SIDE_SELL;
            if (side == SIDE_BUY) crossed = scaled <= 64'(vwap) * (BAND_ONE - bnd);
            else                  crossed = scaled >= 64'(vwap) * (BAND_ONE + bnd);
            r.submitted = p.qty;
            if (!crossed) begin
               r.verdict = VERDICT_REJECT_BAND;
               insert = 0;
            end else begin
               q = 64'(p.qty); m = 64'(mkt_qty); s = 64'(usr_qty); lim = 64'(cap);
               r.verdict = VERDICT_ACCEPTED;
               if (q > 64'(max_qty)) begin
                  q = 64'(max_qty);
                  r.verdict = VERDICT_PARTIAL_MAX;
               end
               u = s + q;
               t = m + u;
               exceed = (t == 0) ? (lim < CAP_FULL) : (u * CAP_FULL > lim * t);
               if (exceed) begin
                  maxu    = (lim < CAP_FULL) ? (lim * m) / (CAP_FULL - lim) : 64'd0;
                  allowed = (maxu > s) ? maxu - s : 64'd0;
                  if (allowed == 0) begin
                     r.verdict = VERDICT_REJECT_CAP;
                     insert = 0;
                     q = 0;
                  end else begin
                     if (allowed < q) q = allowed;
                     r.verdict = VERDICT_PARTIAL_CAP;
                  end
               end
               r.granted = q[19:0];
            end
         end
         if (insert) begin
            if (held >= DEPTH) begin
               r.overflow = 1;
            end else begin
               ring_time[wr_slot]     = p.ts;
               ring_qty[wr_slot]      = r.granted;
               ring_notional[wr_slot] = p.notional;
               ring_user[wr_slot]     = p.is_user;
               wr_slot = (wr_slot + 1 >= DEPTH) ? 0 : wr_slot + 1;
               held++;
               if (p.is_user) begin
                  usr_qty = usr_qty + 30'(r.granted);
               end else begin
                  mkt_notional = mkt_notional + 62'(p.notional);
                  mkt_qty      = mkt_qty + 30'(r.granted);
               end
               recompute_vwap();
            end
         end
         if (!p.is_user) r.granted = '0;
         r.side = side;
         r.vwap = vwap;
         expected_q.push_back(r);
      endfunction

      task report(string msg);
         $display("[%0t] MISMATCH %s", $realtime, msg);
         errors++;
      endtask

      task check_result(gate_result_type got);
         gate_result_type exp_r;
         results++;
         if (expected_q.size() == 0) begin
            report("result with no print outstanding");
            return;
         end
         exp_r = expected_q.pop_front();
         verdict_count[exp_r.verdict]++;
         if (exp_r.overflow) overflow_count++;
         if (got.verdict !== exp_r.verdict)
            report($sformatf("verdict got %0d exp %0d", got.verdict, exp_r.verdict));
         if (got.side !== exp_r.side)
            report($sformatf("side got %0d exp %0d", got.side, exp_r.side));
         if (got.submitted !== exp_r.submitted)
            report($sformatf("submitted got %0d exp %0d", got.submitted, exp_r.submitted));
         if (got.granted !== exp_r.granted)
            report($sformatf("granted got %0d exp %0d", got.granted, exp_r.granted));
         if (got.vwap !== exp_r.vwap)
            report($sformatf("vwap got %0d exp %0d", got.vwap, exp_r.vwap));
         if (got.overflow !== exp_r.overflow)
            report($sformatf("overflow got %0d exp %0d", got.overflow, exp_r.overflow));
      endtask
   endclass

   //---------------------------------------------------------------------------
   // Clock, DUT and signals
   //---------------------------------------------------------------------------
   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [63:0] req_timestamp_ns = '0;
   logic [31:0] req_price = '0;
   logic [19:0] req_quantity = '0;
   logic [51:0] req_notional = '0;
   logic        req_is_user = 0;
   logic [1:0]  req_side_in = '0;
   logic        rsp_valid;
   logic [2:0]  rsp_verdict;
   logic [1:0]  rsp_side_out;
   logic [19:0] rsp_submitted_qty;
   logic [19:0] rsp_granted_qty;
   logic [31:0] rsp_window_vwap;
   logic        rsp_overflow;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;

   vwap_gate_scoreboard sb = new();
   int prints_sent = 0;
   int reg_writes  = 0;

   always #1 clock = ~clock;

   vwap_window_order_gate i_dut (
      .clock, .reset, .start, .busy,
      .req_timestamp_ns, .req_price, .req_quantity, .req_notional,
      .req_is_user, .req_side_in,
      .rsp_valid, .rsp_verdict, .rsp_side_out, .rsp_submitted_qty,
      .rsp_granted_qty, .rsp_window_vwap, .rsp_overflow,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata
   );

   // Result monitor: the strobe lasts one cycle and cannot be stalled, so each
   // rising edge with rsp_valid high is one result transaction.
   always @(posedge clock) begin
      gate_result_type got;
      if (!reset && rsp_valid) begin
         got.verdict   = rsp_verdict;
         got.side      = rsp_side_out;
         got.submitted = rsp_submitted_qty;
         got.granted   = rsp_granted_qty;
         got.vwap      = rsp_window_vwap;
         got.overflow  = rsp_overflow;
         sb.check_result(got);
      end
   end

   //---------------------------------------------------------------------------
   // Drivers. Inputs move on the falling edge; handshakes are sampled on the
   // rising edge. start is left high across back-to-back transactions.
   //---------------------------------------------------------------------------
   task send_print(print_type p, int gap);
      @(negedge clock);
      start            = 1;
      req_timestamp_ns = p.ts;
      req_price        = p.price;
      req_quantity     = p.qty;
      req_notional     = p.notional;
      req_is_user      = p.is_user;
      req_side_in      = p.side;
      do @(posedge clock); while (busy);
      sb.note_print(p);
      prints_sent++;
      if (gap > 0) begin
         @(negedge clock);
         start = 0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task write_csr(logic [1:0] idx, logic [63:0] data);
      @(negedge clock);
      csr_valid = 1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
      reg_writes++;
      @(negedge clock);
      csr_valid = 0;
   endtask

   // Drain: every print gives a result, so an empty queue plus low busy means
   // the block is idle and registers may be written.
   task wait_idle();
      @(negedge clock);
      start = 0;
      while (sb.pending() > 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task configure(logic [63:0] win, logic [19:0] mq, logic [23:0] bd, logic [16:0] cp);
      wait_idle();
      write_csr(CSR_WINDOW, win);
      write_csr(CSR_MAXQTY, 64'(mq));
      write_csr(CSR_BAND, 64'(bd));
      write_csr(CSR_CAP, 64'(cp));
   endtask

   function print_type make_print(logic [63:0] ts, logic [31:0] price, logic [19:0] qty,
                                  logic [51:0] notional, logic is_user, logic [1:0] side);
      print_type p;
      p.ts = ts; p.price = price; p.qty = qty;
      p.notional = notional; p.is_user = is_user; p.side = side;
      return p;
   endfunction

   // User price near the current VWAP so the band test goes both ways.
   function logic [31:0] near_vwap(int spread);
      longint v, d;
      v = longint'(sb.vwap);
      d = longint'($urandom_range(0, 2 * spread)) - spread;
      v = v + d;
      if (v < 0) v = 0;
      if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
      return v[31:0];
   endfunction

   //---------------------------------------------------------------------------
   // Stimulus
   //---------------------------------------------------------------------------
   initial begin
      logic [63:0] ts, win, step_max;
      logic [31:0] center, price;
      logic [19:0] qty, mq;
      logic [23:0] bd;
      logic [16:0] cp;
      int          n_items, gap, calm, spread;
      print_type   p;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: short window, tight max clamp.
      configure(64'd1000, 20'd500, 24'd0, 17'd65536);
      ts = 0;
      send_print(make_print(ts, 32'd1000, 20'd10, 52'd10000, 1, 2'd3), 0); // gate closed
      send_print(make_print(ts, 32'd0, 20'd0, 52'd0, 0, 2'd0), 1);          // all-zero print
      send_print(make_print(ts, 32'hFFFF_FFFF, 20'hFFFFF, 52'hF_FFFF_FFFF_FFFF, 0, 2'd3), 0);
      send_print(make_print(ts, 32'd7, 20'd1, 52'hF_FFFF_FFFF_FFFF, 0, 2'd2), 2); // VWAP saturates
      for (int i = 0; i < 20; i++) begin
         ts = ts + 55;
         send_print(make_print(ts, 32'd1000 + i, 20'd10, 52'(10 * (1000 + i)), 0, 2'd1), i % 3);
      end
      send_print(make_print(ts, sb.vwap - 1, 20'd100, 52'd0, 1, SIDE_BUY), 0);
      send_print(make_print(ts, sb.vwap + 1, 20'd100, 52'd0, 1, SIDE_SELL), 0);
      send_print(make_print(ts, sb.vwap, 20'hFFFFF, 52'd0, 1, SIDE_UNKNOWN), 0); // over max
      send_print(make_print(ts, sb.vwap + 5, 20'd50, 52'd0, 1, 2'd3), 0);
      send_print(make_print(ts, sb.vwap + 5, 20'd50, 52'd0, 1, SIDE_BUY), 0);    // band reject

      // Random phases across window, clamp, band and cap settings.
      for (int ph = 0; ph < 9; ph++) begin
         case (ph)
            0: win = 64'd0;
            1: win = 64'd2000;
            2: win = 64'hFFFF_FFFF_FFFF_FFFF;   // nothing expires: ring fills up
            3: win = 64'd5000;
            default: win = 64'($urandom_range(100, 100000));
         endcase
         case (ph % 4)
            0: mq = 20'hFFFFF;
            1: mq = 20'd0;
            2: mq = 20'($urandom);
            default: mq = 20'($urandom_range(1, 5000));
         endcase
         case ((ph + 1) % 4)
            0: bd = 24'd0;
            1: bd = 24'd10000000;
            2: bd = 24'hFFFFFF;
            default: bd = 24'($urandom_range(0, 3000));
         endcase
         case ((ph + 2) % 5)
            0: cp = 17'd65536;
            1: cp = 17'd0;
            2: cp = 17'h1FFFF;
            default: cp = 17'($urandom_range(1000, 65535));
         endcase
         configure(win, mq, bd, cp);
         n_items  = (ph == 2) ? 1100 : 120;
         step_max = (win > 64'd40000) ? 64'd5000 : win / 8 + 3;
         center   = (ph == 5) ? $urandom : 32'($urandom_range(1, 1000000));
         if (ph % 2 == 1) ts = {$urandom, $urandom};
         calm = 0;
         for (int i = 0; i < n_items; i++) begin
            if (i % 50 == 0) calm = ($urandom_range(0, 9) < 3);
            gap = calm ? 0 : $urandom_range(0, 8);
            if ($urandom_range(0, 99) < 3) ts = ts - 64'($urandom_range(0, 200));
            else ts = ts + 64'($urandom_range(0, int'(step_max)));
            if ($urandom_range(0, 99) < 60 || ph == 2 && $urandom_range(0, 9) < 8) begin
               price = center + 32'($urandom_range(0, center / 50 + 1));
               qty   = ($urandom_range(0, 9) == 0) ? 20'($urandom)
                                                   : 20'($urandom_range(1, 2000));
               p = make_print(ts, price, qty, 52'(64'(price) * 64'(qty)), 0,
                              2'($urandom_range(0, 3)));
               if ($urandom_range(0, 19) == 0) p.notional = 52'({$urandom, $urandom});
            end else begin
               spread = int'(sb.vwap / 100) + 2;
               qty = ($urandom_range(0, 9) == 0) ? 20'($urandom)
                                                 : 20'($urandom_range(0, 4000));
               p = make_print(ts, near_vwap(spread), qty, 52'({$urandom, $urandom}), 1,
                              2'($urandom_range(0, 3)));
            end
            send_print(p, gap);
         end
      end

      // Drain and let the block settle.
      wait_idle();
      repeat (300) @(posedge clock);
      $display("Covered %0d prints, %0d results, %0d register writes, %0d overflows",
               prints_sent, sb.results, reg_writes, sb.overflow_count);
      $display("Verdicts nord/mkt/acc/pmax/pcap/rband/rcap: %0d %0d %0d %0d %0d %0d %0d",
               sb.verdict_count[0], sb.verdict_count[1], sb.verdict_count[2],
               sb.verdict_count[3], sb.verdict_count[4], sb.verdict_count[5],
               sb.verdict_count[6]);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("** vwap_window_order_gate: PASSED **");
      end else begin
         $display("** vwap_window_order_gate: FAILED **");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #100_000_000;
      $display("Timeout with %0d results outstanding", sb.pending());
      $display("** vwap_window_order_gate: FAILED **");
      $finish;
   end

endmodule

// File: vwap_window_order_gate.f
+incdir+rtl
rtl/vwg_pkg.sv
rtl/vwg_divider.sv
rtl/vwg_ring.sv
rtl/vwap_window_order_gate.sv
tb/vwap_window_order_gate_tb.sv
